FILE: rtl/haptic_motion_gain_envelope_core_assert.svh
// Assertion macros for the checker file of the haptic gain envelope core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef HAPTIC_MOTION_GAIN_ENVELOPE_CORE_ASSERT_SVH
`define HAPTIC_MOTION_GAIN_ENVELOPE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HMGE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HMGE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hmge_pkg.sv
// Shared types, codes and fixed-point constants for the haptic gain envelope core.
// No dependencies; the controller, datapath, top level and checker import this package.
package hmge_pkg;

    // Fraction bits of every gain value (Q0.16).
    localparam int GAIN_FRAC_BITS = 16;

    // Reciprocal multipliers used in place of the divisions by full scale.
    localparam int SPEED_RECIP_SHIFT = 18;
    localparam int ACCEL_RECIP_SHIFT = 20;
    localparam logic [16:0] SPEED_RECIP = 17'd52429;
    localparam logic [16:0] ACCEL_RECIP = 17'd69906;

    // Full-scale and deadband thresholds on the raw Q8.8 inputs.
    localparam logic [14:0] SPEED_FULL_RAW     = 15'd5120;
    localparam logic [15:0] ACCEL_FULL_RAW     = 16'd7680;
    localparam logic [14:0] SPEED_DEADBAND_RAW = 15'd64;
    localparam logic [15:0] LOAD_DEADBAND_RAW  = 16'd384;

    // Gain constants in Q0.16.
    localparam logic [16:0] ONE_Q   = 17'h10000;
    localparam logic [14:0] C_FLOOR = 15'd5898;
    localparam logic [16:0] C_SPEED = 17'd9175;
    localparam logic [16:0] C_LOAD  = 17'd13107;
    localparam logic [16:0] C_TEX   = 17'd42598;
    localparam logic [14:0] C_CAP   = 15'd23593;
    localparam logic [14:0] C_EPS   = 15'd7;

    // Configuration register reset values.
    localparam logic [15:0] ATTACK_RESET  = 16'd22938;
    localparam logic [15:0] RELEASE_RESET = 16'd14418;
    localparam logic [15:0] SCALE_RESET   = 16'd16384;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_ATTACK_ALPHA   = 2'd0,
        REG_RELEASE_ALPHA  = 2'd1,
        REG_AIRBORNE_SCALE = 2'd2
    } reg_index_t;

    // One motion sample.
    typedef struct packed {
        logic               authority_active;
        logic               airborne;
        logic signed [15:0] speed;
        logic signed [15:0] acceleration;
    } sample_t;

    // One result.
    typedef struct packed {
        logic [14:0] body_gain;
        logic [15:0] texture_level;
    } result_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_TERM,
        ST_TARGET,
        ST_TEX,
        ST_BLEND,
        ST_UPDATE
    } state_t;

    // Datapath steps issued by the controller.
    typedef enum logic [2:0] {
        STEP_NONE,
        STEP_CAPTURE,
        STEP_NORM,
        STEP_TERM,
        STEP_TARGET,
        STEP_TEX,
        STEP_BLEND,
        STEP_UPDATE
    } step_t;

    typedef struct packed {
        step_t step;
    } cmd_t;

    typedef struct packed {
        logic result_free;
    } status_t;

endpackage

FILE: rtl/hmge_datapath.sv
// Datapath of the haptic gain envelope core: configuration registers, two shared
// multipliers, intermediate registers, smoother state and result register. Uses hmge_pkg.
module hmge_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [1:0]       cfg_index,
    input  logic [15:0]      cfg_data,
    input  hmge_pkg::sample_t sample,
    input  hmge_pkg::cmd_t   cmd,
    output hmge_pkg::status_t status,
    output logic             result_valid,
    input  logic             result_stall,
    output hmge_pkg::result_t result
);
    import hmge_pkg::*;

    logic [15:0] attack_reg, attack_next;
    logic [15:0] release_reg, release_next;
    logic [15:0] scale_reg, scale_next;
    sample_t     in_reg, in_next;
    logic [33:0] p0_reg, p0_next;
    logic [33:0] p1_reg, p1_next;
    logic [16:0] load01_reg, load01_next;
    logic [14:0] tgt_raw_reg, tgt_raw_next;
    logic [14:0] tgt_reg, tgt_next;
    logic [15:0] tex_raw_reg, tex_raw_next;
    logic [15:0] tex_reg, tex_next;
    logic        up_reg, up_next;
    logic [14:0] sb_reg, sb_next;
    result_t     result_reg, result_next;
    logic        result_valid_reg, result_valid_next;

    logic [16:0] opa0, opb0, opa1, opb1;
    logic        mul_en;
    logic [12:0] s13, a13;
    logic [15:0] acc_bits, amag;
    logic        spd_pos, spd_sat, acc_sat, zone;
    logic [16:0] unit_speed, unit_load;
    logic [14:0] tgt_raw, tgt_sel, tgt_capped, diff, d_step, sb_step, sb_new;
    logic [15:0] alpha, tex_sel;
    logic        up;
    logic [33:0] prod0, prod1;

    // Normalization of the captured sample from the reciprocal products.
    always_comb
    begin
        s13      = in_reg.speed[12:0];
        acc_bits = in_reg.acceleration;
        amag     = acc_bits[15] ? (~acc_bits + 16'd1) : acc_bits;
        a13      = amag[12:0];
        spd_pos  = !in_reg.speed[15] && (in_reg.speed != 16'sd0);
        spd_sat  = in_reg.speed[14:0] >= SPEED_FULL_RAW;
        acc_sat  = amag >= ACCEL_FULL_RAW;
        zone     = (!in_reg.speed[15] && (in_reg.speed[14:0] > SPEED_DEADBAND_RAW))
                   || (amag > LOAD_DEADBAND_RAW);
        if (!spd_pos)
        begin
            unit_speed = '0;
        end
        else if (spd_sat)
        begin
            unit_speed = ONE_Q;
        end
        else
        begin
            unit_speed = 17'({s13, 3'b000}) + 17'({s13, 2'b00})
                         + 17'(p0_reg[SPEED_RECIP_SHIFT +: 12]);
        end
        unit_load = acc_sat ? ONE_Q
                            : 17'({a13, 3'b000}) + 17'(p1_reg[ACCEL_RECIP_SHIFT +: 12]);
    end

    // Target, texture and smoother arithmetic on registered products.
    always_comb
    begin
        tgt_raw    = zone ? C_FLOOR + p0_reg[GAIN_FRAC_BITS +: 15]
                            + p1_reg[GAIN_FRAC_BITS +: 15] : '0;
        tgt_sel    = in_reg.airborne ? p0_reg[GAIN_FRAC_BITS +: 15] : tgt_raw_reg;
        tgt_capped = (tgt_sel > C_CAP) ? C_CAP : tgt_sel;
        up         = tgt_reg > sb_reg;
        diff       = up ? (tgt_reg - sb_reg) : (sb_reg - tgt_reg);
        alpha      = up ? attack_reg : release_reg;
        tex_sel    = in_reg.airborne ? p1_reg[GAIN_FRAC_BITS +: 16] : tex_raw_reg;
        d_step     = p0_reg[GAIN_FRAC_BITS +: 15];
        sb_step    = up_reg ? (sb_reg + d_step) : (sb_reg - d_step);
        if (!in_reg.authority_active || (sb_step < C_EPS))
        begin
            sb_new = '0;
        end
        else if (sb_step > C_CAP)
        begin
            sb_new = C_CAP;
        end
        else
        begin
            sb_new = sb_step;
        end
    end

    // Step sequencing: operand selection and register updates.
    always_comb
    begin
        attack_next       = attack_reg;
        release_next      = release_reg;
        scale_next        = scale_reg;
        in_next           = in_reg;
        load01_next       = load01_reg;
        tgt_raw_next      = tgt_raw_reg;
        tgt_next          = tgt_reg;
        tex_raw_next      = tex_raw_reg;
        tex_next          = tex_reg;
        up_next           = up_reg;
        sb_next           = sb_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        opa0   = '0;
        opb0   = '0;
        opa1   = '0;
        opb1   = '0;
        mul_en = 1'b0;

        if (cfg_write_en)
        begin
            case (cfg_index)
                REG_ATTACK_ALPHA:   attack_next  = cfg_data;
                REG_RELEASE_ALPHA:  release_next = cfg_data;
                REG_AIRBORNE_SCALE: scale_next   = cfg_data;
                default: ;
            endcase
        end

        // A transfer on the result channel frees the output register.
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (cmd.step)
            STEP_CAPTURE:
            begin
                in_next = sample;
            end
            STEP_NORM:
            begin
                opa0   = 17'({s13, 2'b00});
                opb0   = SPEED_RECIP;
                opa1   = 17'({a13, 3'b000});
                opb1   = ACCEL_RECIP;
                mul_en = 1'b1;
            end
            STEP_TERM:
            begin
                load01_next = unit_load;
                opa0   = unit_speed;
                opb0   = C_SPEED;
                opa1   = unit_load;
                opb1   = C_LOAD;
                mul_en = 1'b1;
            end
            STEP_TARGET:
            begin
                tgt_raw_next = tgt_raw;
                opa0   = 17'(tgt_raw);
                opb0   = 17'(scale_reg);
                opa1   = load01_reg;
                opb1   = C_TEX;
                mul_en = 1'b1;
            end
            STEP_TEX:
            begin
                tgt_next     = tgt_capped;
                tex_raw_next = p1_reg[GAIN_FRAC_BITS +: 16];
                opa1   = 17'(p1_reg[GAIN_FRAC_BITS +: 16]);
                opb1   = 17'(scale_reg);
                mul_en = 1'b1;
            end
            STEP_BLEND:
            begin
                up_next  = up;
                tex_next = tex_sel;
                opa0   = 17'(diff);
                opb0   = 17'(alpha);
                mul_en = 1'b1;
            end
            STEP_UPDATE:
            begin
                sb_next                   = sb_new;
                result_next.body_gain     = sb_new;
                result_next.texture_level = in_reg.authority_active ? tex_reg : '0;
                result_valid_next         = 1'b1;
            end
            default: ;
        endcase

        prod0   = opa0 * opb0;
        prod1   = opa1 * opb1;
        p0_next = mul_en ? prod0 : p0_reg;
        p1_next = mul_en ? prod1 : p1_reg;
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg       <= ATTACK_RESET;
            release_reg      <= RELEASE_RESET;
            scale_reg        <= SCALE_RESET;
            sb_reg           <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            attack_reg       <= attack_next;
            release_reg      <= release_next;
            scale_reg        <= scale_next;
            sb_reg           <= sb_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        in_reg      <= in_next;
        p0_reg      <= p0_next;
        p1_reg      <= p1_next;
        load01_reg  <= load01_next;
        tgt_raw_reg <= tgt_raw_next;
        tgt_reg     <= tgt_next;
        tex_raw_reg <= tex_raw_next;
        tex_reg     <= tex_next;
        up_reg      <= up_next;
        result_reg  <= result_next;
    end

    assign status.result_free = !result_valid_reg || !result_stall;
    assign result_valid       = result_valid_reg;
    assign result             = result_reg;

endmodule

FILE: rtl/hmge_ctrl.sv
// Controller of the haptic gain envelope core: steps one sample through the datapath.
// Uses hmge_pkg; drives the datapath only through cmd_t and reads status_t.
module hmge_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_stall,
    output hmge_pkg::cmd_t    cmd,
    input  hmge_pkg::status_t status
);
    import hmge_pkg::*;

    state_t state_reg, state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (sample_valid) state_next = ST_NORM;
            ST_NORM:   state_next = ST_TERM;
            ST_TERM:   state_next = ST_TARGET;
            ST_TARGET: state_next = ST_TEX;
            ST_TEX:    state_next = ST_BLEND;
            ST_BLEND:  state_next = ST_UPDATE;
            ST_UPDATE: if (status.result_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs: the step for the datapath and the input stall.
    always_comb
    begin
        sample_stall = 1'b1;
        cmd.step     = STEP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                sample_stall = 1'b0;
                if (sample_valid)
                begin
                    cmd.step = STEP_CAPTURE;
                end
            end
            ST_NORM:   cmd.step = STEP_NORM;
            ST_TERM:   cmd.step = STEP_TERM;
            ST_TARGET: cmd.step = STEP_TARGET;
            ST_TEX:    cmd.step = STEP_TEX;
            ST_BLEND:  cmd.step = STEP_BLEND;
            ST_UPDATE: if (status.result_free) cmd.step = STEP_UPDATE;
            default:   cmd.step = STEP_NONE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/haptic_motion_gain_envelope_core.sv
// Top level of the haptic gain envelope core: controller plus datapath.
// Depends on hmge_pkg, hmge_ctrl and hmge_datapath.
//
// Each motion sample is taken in the idle state and then goes through six
// dependent steps through the datapath's two 17x17 multipliers (normalize, weight,
// airborne scale of the target, texture scale, smoother blend, state update), each step
// using the products registered by the one before. One sample is in flight at a time;
// the next is taken as soon as the result has moved into the output register, so a
// waiting result does not hold off the next sample unless an older result is still
// stalled when the new one finishes. Configuration registers are written with
// cfg_write_en, cfg_index and cfg_data and must only change while no sample is in flight.
module haptic_motion_gain_envelope_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  logic              sample_valid,
    output logic              sample_stall,
    input  hmge_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_stall,
    output hmge_pkg::result_t result
);
    import hmge_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    hmge_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .cmd          (cmd),
        .status       (status)
    );

    // Arithmetic and state.
    hmge_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample       (sample),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: rtl/hmge_checker.sv
// Port-level checks for the haptic gain envelope core, bound to its top level.
// Depends on hmge_pkg and haptic_motion_gain_envelope_core_assert.svh.
`include "haptic_motion_gain_envelope_core_assert.svh"

module hmge_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_stall,
    input logic              result_valid,
    input logic              result_stall,
    input hmge_pkg::result_t result
);
    import hmge_pkg::*;

    // A stalled result stays valid and unchanged.
    `HMGE_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "result changed while stalled")

    // The core works on one sample at a time, so a transfer is followed by a stall.
    `HMGE_ASSERT_NEXT(a_one_in_flight, sample_valid && !sample_stall, sample_stall, "second sample taken while one is in flight")

    // The smoothed gain is either zero or between the snap threshold and the cap.
    `HMGE_ASSERT_SAME(a_body_range, result_valid, (result.body_gain == '0) || ((result.body_gain >= C_EPS) && (result.body_gain <= C_CAP)), "body gain out of range")

    // The texture level never exceeds the texture weight C_TEX.
    `HMGE_ASSERT_SAME(a_texture_cap, result_valid, result.texture_level <= C_TEX[15:0], "texture level above cap")

endmodule

bind haptic_motion_gain_envelope_core hmge_checker u_checker (.*);
